>>> rtl/core/csmc_pkg.sv
package csmc_pkg;

    localparam int CntW = 16;

    typedef enum logic [3:0] {
        MODE_INIT   = 4'd0,
        MODE_TIME   = 4'd1,
        MODE_HOUR   = 4'd2,
        MODE_MINUTE = 4'd3,
        MODE_YEAR   = 4'd4,
        MODE_MONTH  = 4'd5,
        MODE_DAY    = 4'd6,
        MODE_TEMP   = 4'd7,
        MODE_DATE   = 4'd8,
        MODE_HEART  = 4'd9
    } mode_t;

    localparam logic [3:0] CODE_BLANK     = 4'd10;
    localparam logic [3:0] CODE_HEART     = 4'd13;
    localparam logic [3:0] CODE_HEART_INV = 4'd14;
    localparam logic [15:0] DISP_BLANK    = 16'hAAAA;

    localparam logic [1:0] KEY_SET  = 2'd0;
    localparam logic [1:0] KEY_BEEP = 2'd1;
    localparam logic [1:0] KEY_UP   = 2'd2;
    localparam logic [1:0] KEY_DOWN = 2'd3;

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_HALF_SEC = 2'd1;
    localparam logic [1:0] REG_ONE_SEC  = 2'd2;

    localparam logic [CntW-1:0] DEBOUNCE_RESET = 16'd10;
    localparam logic [CntW-1:0] HALF_SEC_RESET = 16'd50;
    localparam logic [CntW-1:0] ONE_SEC_RESET  = 16'd100;

    // press events from the key scan toward the mode logic
    typedef struct packed {
        logic [3:0] pressed;
        logic [3:0] event_ok;
    } key_stat_t;

    // two decimal digits of a value below 128, tens taken mod 10
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [14:0] q;
        logic [3:0]  t;
        logic [6:0]  u;
        begin
            // v * 205 / 2048 is v / 10 for every 7-bit value
            q = {8'd0, v} * 15'd205;
            t = q[14:11];
            u = v - ({3'd0, t} * 7'd10);
            if (t >= 4'd10) t = t - 4'd10;
            bcd2 = {t, u[3:0]};
        end
    endfunction

endpackage

>>> rtl/core/csmc_keys.sv
module csmc_keys (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic                       tick,
    input  logic [3:0]                 level,
    input  logic [csmc_pkg::CntW-1:0]  debounce_ticks,
    input  logic [3:0]                 armed_clr,
    output csmc_pkg::key_stat_t        stat
);
    import csmc_pkg::*;

    logic [CntW-1:0] cnt_reg [4];
    logic [3:0]      pressed_reg;
    logic [3:0]      armed_reg;
    logic [3:0]      pressed_next;
    logic [3:0]      armed_next;
    logic [CntW-1:0] cnt_next [4];

    // count down, then scan levels
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            cnt_next[k] = (tick && cnt_reg[k] != '0) ? cnt_reg[k] - 1'b1 : cnt_reg[k];
            pressed_next[k] = pressed_reg[k];
            armed_next[k] = armed_reg[k];
            if (level[k]) begin
                pressed_next[k] = 1'b0;
                armed_next[k] = 1'b1;
                cnt_next[k] = debounce_ticks;
            end else if (cnt_next[k] == '0) begin
                pressed_next[k] = 1'b1;
            end
        end
    end

    assign stat.pressed  = pressed_next;
    assign stat.event_ok = pressed_next & armed_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg <= '0;
            armed_reg <= '0;
            for (int k = 0; k < 4; k++) cnt_reg[k] <= '0;
        end else if (step) begin
            pressed_reg <= pressed_next;
            armed_reg <= armed_next & ~armed_clr;
            for (int k = 0; k < 4; k++) cnt_reg[k] <= cnt_next[k];
        end
    end

`ifndef NO_ASSERTIONS
    a_event_needs_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.event_ok & ~stat.pressed) == 4'd0) else $error("event without press");
    a_release_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && level[0]) |=> armed_reg[0]) else $error("release did not arm");
    a_release_unpresses: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && level[2]) |=> !pressed_reg[2]) else $error("release kept press");
`endif
endmodule

>>> rtl/core/csmc_core.sv
module csmc_core #(
    parameter logic [csmc_pkg::CntW-1:0] PERIOD_INIT = csmc_pkg::ONE_SEC_RESET
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic                       tick,
    input  csmc_pkg::key_stat_t        keys,
    input  logic [csmc_pkg::CntW-1:0]  half_second_ticks,
    input  logic [csmc_pkg::CntW-1:0]  one_second_ticks,
    input  logic [4:0]                 rtc_hour,
    input  logic [5:0]                 rtc_minute,
    input  logic [6:0]                 rtc_year,
    input  logic [3:0]                 rtc_month,
    input  logic [4:0]                 rtc_day,
    output logic [3:0]                 armed_clr,
    output logic [3:0]                 mode_o,
    output logic [15:0]                disp_o,
    output logic [3:0]                 flags_o,
    output logic                       strobe_o,
    output logic [4:0]                 hour_o,
    output logic [5:0]                 minute_o,
    output logic [6:0]                 year_o,
    output logic [3:0]                 month_o,
    output logic [4:0]                 day_o
);
    import csmc_pkg::*;

    mode_t           mode_reg, mode_next;
    logic [4:0]      hour_reg, hour_next;
    logic [5:0]      minute_reg, minute_next;
    logic [6:0]      year_reg, year_next;
    logic [3:0]      month_reg, month_next;
    logic [4:0]      day_reg, day_next;
    logic [CntW-1:0] period_reg, period_next, period_dec;
    logic [CntW-1:0] hold_reg, hold_next, hold_dec;
    logic [15:0]     disp_reg, disp_next;
    logic [3:0]      flag_reg, flag_next;
    logic            strobe;
    logic [3:0]      ev;
    logic [3:0]      clr;
    logic [6:0]      v, lo, hi;
    logic            pos2;
    logic [7:0]      pr;
    logic [4:0]      dlim;
    logic [7:0]      yd;

    // day limit from month and leap year
    always_comb begin
        case (month_reg)
            4'd2:    dlim = (year_reg[1:0] == 2'd0) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: dlim = 5'd30;
            default: dlim = 5'd31;
        endcase
    end

    assign period_dec = (tick && period_reg != '0) ? period_reg - 1'b1 : period_reg;
    assign hold_dec   = (tick && hold_reg != '0) ? hold_reg - 1'b1 : hold_reg;

    // one pass of the mode handler, all moves in sequence
    always_comb begin
        mode_next = mode_reg;
        hour_next = hour_reg; minute_next = minute_reg; year_next = year_reg;
        month_next = month_reg; day_next = day_reg;
        period_next = period_dec; hold_next = hold_dec;
        disp_next = disp_reg; flag_next = flag_reg;
        strobe = 1'b0;
        ev = keys.event_ok;
        clr = 4'b0000;
        v = 7'd0; lo = 7'd0; hi = 7'd0; pos2 = 1'b0; pr = 8'd0; yd = 8'd0;
        // beep key event is consumed with no effect
        if (ev[KEY_BEEP]) clr[KEY_BEEP] = 1'b1;
        case (mode_reg)
            MODE_INIT: begin
                if (period_dec == '0) begin
                    mode_next = MODE_TIME;
                    disp_next = DISP_BLANK;
                    flag_next = {flag_reg[3], 3'b100};
                    period_next = '0;
                    hold_next = one_second_ticks;
                end
            end
            MODE_TIME: begin
                if (period_dec == '0) begin
                    flag_next[0] = ~flag_next[0];
                    period_next = half_second_ticks;
                    hour_next = rtc_hour; minute_next = rtc_minute; year_next = rtc_year;
                    month_next = rtc_month; day_next = rtc_day;
                    disp_next = {bcd2({2'b0, rtc_hour}), bcd2({1'b0, rtc_minute})};
                end
                if (keys.pressed[KEY_SET]) begin
                    clr[KEY_SET] = 1'b1;
                    if (hold_dec == '0) begin
                        mode_next = MODE_HOUR;
                        flag_next = {flag_next[3], 3'b101};
                    end
                end else begin
                    hold_next = one_second_ticks;
                end
                if (ev[KEY_UP]) begin
                    clr[KEY_UP] = 1'b1;
                    mode_next = MODE_TEMP;
                    flag_next = {flag_next[3], 3'b100};
                    disp_next = DISP_BLANK; period_next = '0;
                end
                if (ev[KEY_DOWN]) begin
                    clr[KEY_DOWN] = 1'b1;
                    mode_next = MODE_DATE;
                    flag_next = {flag_next[3], 3'b100};
                    disp_next = DISP_BLANK; period_next = '0;
                end
            end
            MODE_HOUR, MODE_MINUTE, MODE_YEAR, MODE_MONTH, MODE_DAY: begin
                case (mode_reg)
                    MODE_HOUR:   begin v = {2'b0, hour_reg}; hi = 7'd23; end
                    MODE_MINUTE: begin v = {1'b0, minute_reg}; hi = 7'd59; pos2 = 1'b1; end
                    MODE_YEAR:   begin v = year_reg; hi = 7'd99; end
                    MODE_MONTH:  begin v = {3'b0, month_reg}; hi = 7'd12; lo = 7'd1; end
                    default:     begin
                        v = {2'b0, day_reg}; hi = {2'b0, dlim}; pos2 = 1'b1; lo = 7'd1;
                    end
                endcase
                // blink the edited field
                if (period_dec == '0) begin
                    period_next = half_second_ticks;
                    if ((pos2 ? disp_reg[7:4] : disp_reg[15:12]) != CODE_BLANK) begin
                        if (mode_reg == MODE_YEAR) disp_next = DISP_BLANK;
                        else if (pos2) disp_next[7:0] = 8'hAA;
                        else disp_next[15:8] = 8'hAA;
                    end else if (mode_reg == MODE_YEAR) begin
                        disp_next = {8'h20, bcd2(year_reg)};
                    end else begin
                        pr = bcd2(v);
                        if (pos2) disp_next[7:0] = pr; else disp_next[15:8] = pr;
                    end
                end
                if (ev[KEY_UP]) begin
                    clr[KEY_UP] = 1'b1;
                    v = (v + 7'd1 > hi) ? lo : v + 7'd1;
                    pr = bcd2(v);
                    if (mode_reg == MODE_YEAR) disp_next = {8'h20, pr};
                    else if (pos2) disp_next[7:0] = pr;
                    else disp_next[15:8] = pr;
                    period_next = half_second_ticks;
                end
                if (ev[KEY_DOWN]) begin
                    clr[KEY_DOWN] = 1'b1;
                    v = (v > lo) ? v - 7'd1 : hi;
                    pr = bcd2(v);
                    if (mode_reg == MODE_YEAR) disp_next = {8'h20, pr};
                    else if (pos2) disp_next[7:0] = pr;
                    else disp_next[15:8] = pr;
                    period_next = half_second_ticks;
                end
                case (mode_reg)
                    MODE_HOUR:   hour_next = v[4:0];
                    MODE_MINUTE: minute_next = v[5:0];
                    MODE_YEAR:   year_next = v;
                    MODE_MONTH:  month_next = v[3:0];
                    default:     day_next = v[4:0];
                endcase
                if (ev[KEY_SET]) begin
                    clr[KEY_SET] = 1'b1;
                    case (mode_reg)
                        MODE_HOUR: begin
                            mode_next = MODE_MINUTE;
                            disp_next[15:8] = bcd2({2'b0, hour_next});
                            flag_next = {flag_next[3], 3'b101};
                        end
                        MODE_MINUTE: begin
                            mode_next = MODE_YEAR;
                            yd = bcd2(year_next);
                            disp_next = {8'h20, yd};
                            flag_next = {flag_next[3], 3'b000};
                        end
                        MODE_YEAR, MODE_MONTH: begin
                            mode_next = (mode_reg == MODE_YEAR) ? MODE_MONTH : MODE_DAY;
                            disp_next = {bcd2({3'b0, month_next}), bcd2({2'b0, day_next})};
                            flag_next = {flag_next[3], 3'b110};
                        end
                        default: begin
                            strobe = 1'b1;
                            mode_next = MODE_TIME;
                            disp_next = DISP_BLANK;
                            flag_next = {flag_next[3], 3'b100};
                            period_next = '0;
                            hold_next = one_second_ticks;
                        end
                    endcase
                end
            end
            MODE_TEMP: begin
                if (ev[KEY_UP]) begin
                    clr[KEY_UP] = 1'b1;
                    mode_next = MODE_HEART;
                    flag_next = {flag_next[3], 3'b000};
                    disp_next = DISP_BLANK; period_next = '0;
                end
                if (ev[KEY_DOWN]) begin
                    clr[KEY_DOWN] = 1'b1;
                    mode_next = MODE_TIME;
                    disp_next = DISP_BLANK;
                    flag_next = {flag_next[3], 3'b100};
                    period_next = '0; hold_next = one_second_ticks;
                end
            end
            MODE_DATE: begin
                if (period_dec == '0) begin
                    period_next = half_second_ticks;
                    hour_next = rtc_hour; minute_next = rtc_minute; year_next = rtc_year;
                    month_next = rtc_month; day_next = rtc_day;
                    disp_next = {bcd2({3'b0, rtc_month}), bcd2({2'b0, rtc_day})};
                    flag_next[1] = 1'b1;
                end
                if (ev[KEY_UP]) begin
                    clr[KEY_UP] = 1'b1;
                    mode_next = MODE_TIME;
                    disp_next = DISP_BLANK;
                    flag_next = {flag_next[3], 3'b100};
                    period_next = '0; hold_next = one_second_ticks;
                end
                if (ev[KEY_DOWN]) begin
                    clr[KEY_DOWN] = 1'b1;
                    mode_next = MODE_HEART;
                    flag_next = {flag_next[3], 3'b000};
                    disp_next = DISP_BLANK; period_next = '0;
                end
            end
            MODE_HEART: begin
                if (period_dec == '0) begin
                    period_next = one_second_ticks;
                    flag_next[3] = ~flag_reg[3];
                    disp_next = flag_reg[3] ? {4{CODE_HEART}} : {4{CODE_HEART_INV}};
                end
                if (ev[KEY_UP]) begin
                    clr[KEY_UP] = 1'b1;
                    mode_next = MODE_DATE;
                    flag_next = {flag_next[3], 3'b100};
                    disp_next = DISP_BLANK; period_next = '0;
                end
                if (ev[KEY_DOWN]) begin
                    clr[KEY_DOWN] = 1'b1;
                    mode_next = MODE_TEMP;
                    flag_next = {flag_next[3], 3'b100};
                    disp_next = DISP_BLANK; period_next = '0;
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    assign armed_clr = clr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_INIT;
            hour_reg <= 5'd22; minute_reg <= 6'd47; year_reg <= 7'd14;
            month_reg <= 4'd2; day_reg <= 5'd16;
            period_reg <= PERIOD_INIT;
            hold_reg <= '0;
            disp_reg <= DISP_BLANK;
            flag_reg <= '0;
        end else if (step) begin
            mode_reg <= mode_next;
            hour_reg <= hour_next; minute_reg <= minute_next; year_reg <= year_next;
            month_reg <= month_next; day_reg <= day_next;
            period_reg <= period_next;
            hold_reg <= hold_next;
            disp_reg <= disp_next;
            flag_reg <= flag_next;
        end
    end

    assign mode_o = mode_next;
    assign disp_o = disp_next;
    assign flags_o = flag_next;
    assign strobe_o = strobe;
    assign hour_o = hour_next;
    assign minute_o = minute_next;
    assign year_o = year_next;
    assign month_o = month_next;
    assign day_o = day_next;

`ifndef NO_ASSERTIONS
    a_strobe_from_day: assert property (@(posedge aclk) disable iff (!aresetn)
        strobe |-> (mode_reg == MODE_DAY && mode_next == MODE_TIME))
        else $error("strobe outside day exit");
    a_init_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && mode_reg == MODE_INIT && mode_next != MODE_INIT) |=> mode_reg == MODE_TIME)
        else $error("bad init exit");
    a_hold_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(mode_reg) && $stable(disp_reg))
        else $error("state moved without request");
`endif
endmodule

>>> rtl/core/clock_set_mode_controller_unit.sv
// Clock set-mode controller.
// Input channel s_*: one request per control loop pass, carrying the tick flag,
// four raw key levels (0 pressed) and the current clock readings.
// Result channel m_*: one result per request with mode, four display codes,
// display flags, the write strobe and the edited time and date fields.
// Configuration: cfg_we with cfg_index 0 debounce, 1 half second, 2 one second
// tick counts; other indexes are ignored. Write only while idle.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while results are taken; the mode update is a single registered pass.
// The output register is refilled in the same cycle it is taken, so input
// ready is high whenever the result register is empty or being drained.
// When the receiver stalls, the result holds and s_ready drops.
// Reset (aresetn low, synchronous): init mode, time 22:47, date 14-02-16,
// blank display, keys unpressed, registers at 10, 50 and 100.
module clock_set_mode_controller_unit #(
    parameter logic [15:0] DEBOUNCE_DEFAULT = csmc_pkg::DEBOUNCE_RESET,
    parameter logic [15:0] HALF_SEC_DEFAULT = csmc_pkg::HALF_SEC_RESET,
    parameter logic [15:0] ONE_SEC_DEFAULT  = csmc_pkg::ONE_SEC_RESET
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_tick,
    input  logic        s_key_set_level,
    input  logic        s_key_beep_level,
    input  logic        s_key_up_level,
    input  logic        s_key_down_level,
    input  logic [4:0]  s_rtc_hour,
    input  logic [5:0]  s_rtc_minute,
    input  logic [6:0]  s_rtc_year,
    input  logic [3:0]  s_rtc_month,
    input  logic [4:0]  s_rtc_day,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_ui_mode,
    output logic [15:0] m_display_codes,
    output logic        m_colon_on,
    output logic        m_dot_on,
    output logic        m_blink_enable,
    output logic        m_write_strobe,
    output logic [4:0]  m_set_hour,
    output logic [5:0]  m_set_minute,
    output logic [6:0]  m_set_year,
    output logic [3:0]  m_set_month,
    output logic [4:0]  m_set_day
);
    import csmc_pkg::*;

    logic [15:0] deb_reg, half_reg, one_reg;
    logic        step;
    logic        valid_reg;
    key_stat_t   kstat;
    logic [3:0]  armed_clr;
    logic [3:0]  mode_w, flags_w;
    logic [15:0] disp_w;
    logic        strobe_w;
    logic [4:0]  hour_w, day_w;
    logic [5:0]  minute_w;
    logic [6:0]  year_w;
    logic [3:0]  month_w;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg <= DEBOUNCE_DEFAULT;
            half_reg <= HALF_SEC_DEFAULT;
            one_reg <= ONE_SEC_DEFAULT;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEBOUNCE: deb_reg <= cfg_data;
                REG_HALF_SEC: half_reg <= cfg_data;
                REG_ONE_SEC:  one_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_ready = !valid_reg || m_ready;
    assign step = s_valid && s_ready;

    csmc_keys u_keys (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .tick           (s_tick),
        .level          ({s_key_down_level, s_key_up_level, s_key_beep_level,
                          s_key_set_level}),
        .debounce_ticks (deb_reg),
        .armed_clr      (armed_clr),
        .stat           (kstat)
    );

    csmc_core #(
        .PERIOD_INIT (ONE_SEC_DEFAULT)
    ) u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step              (step),
        .tick              (s_tick),
        .keys              (kstat),
        .half_second_ticks (half_reg),
        .one_second_ticks  (one_reg),
        .rtc_hour          (s_rtc_hour),
        .rtc_minute        (s_rtc_minute),
        .rtc_year          (s_rtc_year),
        .rtc_month         (s_rtc_month),
        .rtc_day           (s_rtc_day),
        .armed_clr         (armed_clr),
        .mode_o            (mode_w),
        .disp_o            (disp_w),
        .flags_o           (flags_w),
        .strobe_o          (strobe_w),
        .hour_o            (hour_w),
        .minute_o          (minute_w),
        .year_o            (year_w),
        .month_o           (month_w),
        .day_o             (day_w)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_ui_mode <= mode_w;
            m_display_codes <= disp_w;
            m_colon_on <= flags_w[0];
            m_dot_on <= flags_w[1];
            m_blink_enable <= flags_w[2];
            m_write_strobe <= strobe_w;
            m_set_hour <= hour_w;
            m_set_minute <= minute_w;
            m_set_year <= year_w;
            m_set_month <= month_w;
            m_set_day <= day_w;
        end
    end

    assign m_valid = valid_reg;

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg |-> s_ready) else $error("stalled while empty");
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> valid_reg) else $error("request lost");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_ready) |=> valid_reg && $stable(m_display_codes))
        else $error("result dropped on stall");
`endif
endmodule
